@@ sv/rpm_pkg.sv @@
package rpm_pkg;

  localparam int GRID_BITS  = 5;
  localparam int ADDR_BITS  = 2 * GRID_BITS;
  localparam int GRID_DIM   = 32;
  localparam int GRID_CELLS = GRID_DIM * GRID_DIM;
  localparam int FR_DEPTH   = 256;
  localparam int FR_IDX     = $clog2(FR_DEPTH);
  localparam int FR_CNT     = FR_IDX + 1;
  localparam int RNG_BITS   = 32;
  localparam int DIV_CNT    = $clog2(RNG_BITS);

  typedef logic [2:0] code_t;
  localparam code_t CODE_OPEN   = 3'd1;
  localparam code_t CODE_MAZE   = 3'd2;
  localparam code_t CODE_CARVED = 3'd3;
  localparam code_t CODE_END    = 3'd4;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_WRITE = 2'd0;
  localparam kind_t KIND_GEN   = 2'd1;
  localparam kind_t KIND_READ  = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_OVF   = 2'd2;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_ROWS = 2'd0;
  localparam reg_idx_t REG_COLS = 2'd1;
  localparam reg_idx_t REG_SEED = 2'd2;

  typedef logic [1:0] dir_t;
  localparam dir_t DIR_UP    = 2'd0;
  localparam dir_t DIR_DOWN  = 2'd1;
  localparam dir_t DIR_LEFT  = 2'd2;
  localparam dir_t DIR_RIGHT = 2'd3;

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_ADD_RD   = 17'h00002,
    S_ADD_CHK  = 17'h00004,
    S_SCAN_RD  = 17'h00008,
    S_SCAN_CMP = 17'h00010,
    S_APPEND   = 17'h00020,
    S_LOOP     = 17'h00040,
    S_DIV      = 17'h00080,
    S_PICK_RD  = 17'h00100,
    S_PICK_CAP = 17'h00200,
    S_SH_RD    = 17'h00400,
    S_SH_WR    = 17'h00800,
    S_NB_RD    = 17'h01000,
    S_NB_CHK   = 17'h02000,
    S_NB_END   = 17'h04000,
    S_CARVE    = 17'h08000,
    S_JOIN     = 17'h10000
  } state_t;

  function automatic logic [RNG_BITS-1:0] xorshift(input logic [RNG_BITS-1:0] x);
    logic [RNG_BITS-1:0] a;
    logic [RNG_BITS-1:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

@@ sv/randomized_prim_maze_carver.sv @@
// Write and read requests: one per cycle, result strobed the cycle after accept.
// Generate requests: busy until the result is strobed; each random draw passes a
// bit-serial remainder unit, and frontier scans and order-preserving removals
// walk the frontier memory one entry at a time, with a read and a compare or write.
// Synchronous active-low reset clears control and config; the grid holds no reset.
// The result receiver cannot stall: out_valid is a one-cycle strobe.
module randomized_prim_maze_carver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [4:0]  in_row,
  input  logic [4:0]  in_col,
  input  logic [2:0]  in_cell_code,
  input  logic [4:0]  in_start_row,
  input  logic [4:0]  in_start_col,
  input  logic [4:0]  in_end_row,
  input  logic [4:0]  in_end_col,
  output logic        out_valid,
  output logic [2:0]  out_read_code,
  output logic [10:0] out_joined_cells,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AB = rpm_pkg::ADDR_BITS;
  localparam int GB = rpm_pkg::GRID_BITS;
  localparam int FI = rpm_pkg::FR_IDX;
  localparam int FC = rpm_pkg::FR_CNT;
  localparam int RB = rpm_pkg::RNG_BITS;

  // configuration
  logic [5:0]    rows_cfg_r, cols_cfg_r;
  logic [RB-1:0] seed_r;
  logic [5:0]    rows_eff, cols_eff;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= 6'd32;
      cols_cfg_r <= 6'd32;
      seed_r     <= 32'd1;
    end else if (cfg_wr) begin
      unique case (rpm_pkg::reg_idx_t'(paddr[3:2]))
        rpm_pkg::REG_ROWS: rows_cfg_r <= pwdata[5:0];
        rpm_pkg::REG_COLS: cols_cfg_r <= pwdata[5:0];
        rpm_pkg::REG_SEED: seed_r     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (rpm_pkg::reg_idx_t'(paddr[3:2]))
      rpm_pkg::REG_ROWS: prdata = {26'd0, rows_cfg_r};
      rpm_pkg::REG_COLS: prdata = {26'd0, cols_cfg_r};
      rpm_pkg::REG_SEED: prdata = seed_r;
      default:           prdata = 32'd0;
    endcase
  end

  assign rows_eff = (rows_cfg_r < 6'd3) ? 6'd3 : (rows_cfg_r > 6'd32) ? 6'd32 : rows_cfg_r;
  assign cols_eff = (cols_cfg_r < 6'd3) ? 6'd3 : (cols_cfg_r > 6'd32) ? 6'd32 : cols_cfg_r;

  // grid and frontier memories
  rpm_pkg::code_t grid_mem [rpm_pkg::GRID_CELLS];
  logic [AB-1:0]  fr_mem   [rpm_pkg::FR_DEPTH];

  logic           g_we;
  logic [AB-1:0]  g_wa, g_ra;
  rpm_pkg::code_t g_wd, g_rd_r;
  logic           f_we;
  logic [FI-1:0]  f_wa, f_ra;
  logic [AB-1:0]  f_wd, f_rd_r;

  always_ff @(posedge clk) begin
    if (g_we) grid_mem[g_wa] <= g_wd;
    g_rd_r <= grid_mem[g_ra];
  end

  always_ff @(posedge clk) begin
    if (f_we) fr_mem[f_wa] <= f_wd;
    f_rd_r <= fr_mem[f_ra];
  end

  // sequencer state
  rpm_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [AB-1:0]   cur_r, cur_nxt, end_r, end_nxt;
  rpm_pkg::dir_t   dir_r, dir_nxt;
  logic            chk_r, chk_nxt, ovf_r, ovf_nxt;
  logic [FC-1:0]   idx_r, idx_nxt, fcnt_r, fcnt_nxt;
  logic [RB-1:0]   rng_r, rng_nxt;
  logic [10:0]     joined_r, joined_nxt;
  logic [AB-1:0]   nb_r [4];
  logic [AB-1:0]   nb_wd;
  logic            nb_we;
  logic [2:0]      nbn_r, nbn_nxt;

  // shared remainder unit
  logic [RB-1:0]      dq_r, dq_nxt;
  logic [FC:0]        drem_r, drem_nxt, drem_sh;
  logic [FC-1:0]      dd_r, dd_nxt;
  logic [rpm_pkg::DIV_CNT-1:0] dcnt_r, dcnt_nxt;

  // output registers
  logic          ov_r, ov_nxt, rdsel_r, rdsel_nxt;
  logic [10:0]   oj_r, oj_nxt;
  logic [1:0]    os_r, os_nxt;

  // neighbor two steps away
  logic [6:0]    nrow, ncol;
  logic [AB-1:0] nb_addr;
  logic          nb_ok;
  logic [RB-1:0] rng_adv;
  logic [5:0]    wrow, wcol;
  logic [AB-1:0] nb_sel;
  logic [FC-1:0] idx_inc;
  logic          accept, in_bad, gen_bad;

  always_comb begin
    nrow = {2'd0, cur_r[AB-1:GB]};
    ncol = {2'd0, cur_r[GB-1:0]};
    unique case (dir_r)
      rpm_pkg::DIR_UP:    nrow = nrow - 7'd2;
      rpm_pkg::DIR_DOWN:  nrow = nrow + 7'd2;
      rpm_pkg::DIR_LEFT:  ncol = ncol - 7'd2;
      rpm_pkg::DIR_RIGHT: ncol = ncol + 7'd2;
      default: ;
    endcase
  end

  // a wrapped negative coordinate is large and fails the upper bound
  assign nb_ok = (nrow >= 7'd1) && (nrow <= {1'b0, rows_eff} - 7'd2) &&
                 (ncol >= 7'd1) && (ncol <= {1'b0, cols_eff} - 7'd2);
  assign nb_addr = {nrow[GB-1:0], ncol[GB-1:0]};
  assign rng_adv = rpm_pkg::xorshift(rng_r);
  assign nb_sel  = nb_r[drem_r[1:0]];
  assign wrow    = ({1'b0, cur_r[AB-1:GB]} + {1'b0, nb_sel[AB-1:GB]}) >> 1;
  assign wcol    = ({1'b0, cur_r[GB-1:0]} + {1'b0, nb_sel[GB-1:0]}) >> 1;
  assign idx_inc = idx_r + 1'b1;
  assign drem_sh = {drem_r[FC-1:0], dq_r[RB-1]};

  assign accept  = start & (state_r == rpm_pkg::S_IDLE);
  assign in_bad  = ({1'b0, in_row} >= rows_eff) || ({1'b0, in_col} >= cols_eff);
  assign gen_bad = ({1'b0, in_start_row} >= rows_eff) || ({1'b0, in_start_col} >= cols_eff) ||
                   ({1'b0, in_end_row} >= rows_eff) || ({1'b0, in_end_col} >= cols_eff);

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    cur_nxt    = cur_r;
    end_nxt    = end_r;
    dir_nxt    = dir_r;
    chk_nxt    = chk_r;
    ovf_nxt    = ovf_r;
    idx_nxt    = idx_r;
    fcnt_nxt   = fcnt_r;
    rng_nxt    = rng_r;
    joined_nxt = joined_r;
    nbn_nxt    = nbn_r;
    nb_we      = 1'b0;
    nb_wd      = nb_addr;
    dq_nxt     = dq_r;
    drem_nxt   = drem_r;
    dd_nxt     = dd_r;
    dcnt_nxt   = dcnt_r;
    ov_nxt     = 1'b0;
    rdsel_nxt  = 1'b0;
    oj_nxt     = 11'd0;
    os_nxt     = rpm_pkg::ST_OK;
    g_we       = 1'b0;
    g_wa       = cur_r;
    g_wd       = rpm_pkg::CODE_MAZE;
    g_ra       = nb_addr;
    f_we       = 1'b0;
    f_wa       = fcnt_r[FI-1:0];
    f_wd       = nb_addr;
    f_ra       = idx_r[FI-1:0];

    unique case (state_r)
      rpm_pkg::S_IDLE: begin
        g_ra = {in_row, in_col};
        if (accept) begin
          ov_nxt = 1'b1;
          case (rpm_pkg::kind_t'(in_kind))
            rpm_pkg::KIND_WRITE: begin
              if (in_bad) os_nxt = rpm_pkg::ST_RANGE;
              else begin
                g_we = 1'b1;
                g_wa = {in_row, in_col};
                g_wd = in_cell_code;
              end
            end
            rpm_pkg::KIND_READ: begin
              if (in_bad) os_nxt = rpm_pkg::ST_RANGE;
              else rdsel_nxt = 1'b1;
            end
            rpm_pkg::KIND_GEN: begin
              if (gen_bad) os_nxt = rpm_pkg::ST_RANGE;
              else begin
                ov_nxt     = 1'b0;
                g_we       = 1'b1;
                g_wa       = {in_start_row, in_start_col};
                g_wd       = rpm_pkg::CODE_MAZE;
                rng_nxt    = (seed_r == '0) ? 32'd1 : seed_r;
                fcnt_nxt   = '0;
                joined_nxt = '0;
                ovf_nxt    = 1'b0;
                cur_nxt    = {in_start_row, in_start_col};
                end_nxt    = {in_end_row, in_end_col};
                dir_nxt    = rpm_pkg::DIR_UP;
                chk_nxt    = 1'b0;
                state_nxt  = rpm_pkg::S_ADD_RD;
              end
            end
            default: ;
          endcase
        end
      end

      rpm_pkg::S_ADD_RD: begin
        if (nb_ok) state_nxt = rpm_pkg::S_ADD_CHK;
        else if (dir_r == rpm_pkg::DIR_RIGHT) state_nxt = rpm_pkg::S_LOOP;
        else dir_nxt = dir_r + 1'b1;
      end

      rpm_pkg::S_ADD_CHK: begin
        if (g_rd_r == rpm_pkg::CODE_OPEN) begin
          idx_nxt   = '0;
          state_nxt = chk_r ? rpm_pkg::S_SCAN_RD : rpm_pkg::S_APPEND;
        end else if (dir_r == rpm_pkg::DIR_RIGHT) state_nxt = rpm_pkg::S_LOOP;
        else begin
          dir_nxt   = dir_r + 1'b1;
          state_nxt = rpm_pkg::S_ADD_RD;
        end
      end

      rpm_pkg::S_SCAN_RD: begin
        if (idx_r == fcnt_r) state_nxt = rpm_pkg::S_APPEND;
        else state_nxt = rpm_pkg::S_SCAN_CMP;
      end

      rpm_pkg::S_SCAN_CMP: begin
        if (f_rd_r != nb_addr) begin
          idx_nxt   = idx_inc;
          state_nxt = rpm_pkg::S_SCAN_RD;
        end else if (dir_r == rpm_pkg::DIR_RIGHT) state_nxt = rpm_pkg::S_LOOP;
        else begin
          dir_nxt   = dir_r + 1'b1;
          state_nxt = rpm_pkg::S_ADD_RD;
        end
      end

      rpm_pkg::S_APPEND: begin
        // drop the add and flag it when the frontier is full
        if (fcnt_r == FC'(rpm_pkg::FR_DEPTH)) ovf_nxt = 1'b1;
        else begin
          f_we     = 1'b1;
          fcnt_nxt = fcnt_r + 1'b1;
        end
        if (dir_r == rpm_pkg::DIR_RIGHT) state_nxt = rpm_pkg::S_LOOP;
        else begin
          dir_nxt   = dir_r + 1'b1;
          state_nxt = rpm_pkg::S_ADD_RD;
        end
      end

      rpm_pkg::S_LOOP: begin
        if (fcnt_r == '0) begin
          g_we      = 1'b1;
          g_wa      = end_r;
          g_wd      = rpm_pkg::CODE_END;
          ov_nxt    = 1'b1;
          oj_nxt    = joined_r;
          os_nxt    = ovf_r ? rpm_pkg::ST_OVF : rpm_pkg::ST_OK;
          state_nxt = rpm_pkg::S_IDLE;
        end else begin
          rng_nxt   = rng_adv;
          dq_nxt    = rng_adv;
          drem_nxt  = '0;
          dd_nxt    = fcnt_r;
          dcnt_nxt  = '0;
          ret_nxt   = rpm_pkg::S_PICK_RD;
          state_nxt = rpm_pkg::S_DIV;
        end
      end

      rpm_pkg::S_DIV: begin
        // one restoring step per cycle
        drem_nxt = (drem_sh >= {1'b0, dd_r}) ? drem_sh - {1'b0, dd_r} : drem_sh;
        dq_nxt   = dq_r << 1;
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == '1) state_nxt = ret_r;
      end

      rpm_pkg::S_PICK_RD: begin
        f_ra      = drem_r[FI-1:0];
        idx_nxt   = drem_r[FC-1:0];
        state_nxt = rpm_pkg::S_PICK_CAP;
      end

      rpm_pkg::S_PICK_CAP: begin
        cur_nxt   = f_rd_r;
        state_nxt = rpm_pkg::S_SH_RD;
      end

      rpm_pkg::S_SH_RD: begin
        f_ra = idx_inc[FI-1:0];
        if (idx_inc >= fcnt_r) begin
          fcnt_nxt  = fcnt_r - 1'b1;
          dir_nxt   = rpm_pkg::DIR_UP;
          nbn_nxt   = '0;
          state_nxt = rpm_pkg::S_NB_RD;
        end else state_nxt = rpm_pkg::S_SH_WR;
      end

      rpm_pkg::S_SH_WR: begin
        f_we      = 1'b1;
        f_wa      = idx_r[FI-1:0];
        f_wd      = f_rd_r;
        idx_nxt   = idx_inc;
        state_nxt = rpm_pkg::S_SH_RD;
      end

      rpm_pkg::S_NB_RD: begin
        if (nb_ok) state_nxt = rpm_pkg::S_NB_CHK;
        else if (dir_r == rpm_pkg::DIR_RIGHT) state_nxt = rpm_pkg::S_NB_END;
        else dir_nxt = dir_r + 1'b1;
      end

      rpm_pkg::S_NB_CHK: begin
        if (g_rd_r == rpm_pkg::CODE_MAZE) begin
          nb_we   = 1'b1;
          nbn_nxt = nbn_r + 1'b1;
        end
        if (dir_r == rpm_pkg::DIR_RIGHT) state_nxt = rpm_pkg::S_NB_END;
        else begin
          dir_nxt   = dir_r + 1'b1;
          state_nxt = rpm_pkg::S_NB_RD;
        end
      end

      rpm_pkg::S_NB_END: begin
        if (nbn_r == '0) state_nxt = rpm_pkg::S_LOOP;
        else begin
          rng_nxt   = rng_adv;
          dq_nxt    = rng_adv;
          drem_nxt  = '0;
          dd_nxt    = FC'(nbn_r);
          dcnt_nxt  = '0;
          ret_nxt   = rpm_pkg::S_CARVE;
          state_nxt = rpm_pkg::S_DIV;
        end
      end

      rpm_pkg::S_CARVE: begin
        g_we      = 1'b1;
        g_wa      = {wrow[GB-1:0], wcol[GB-1:0]};
        g_wd      = rpm_pkg::CODE_CARVED;
        state_nxt = rpm_pkg::S_JOIN;
      end

      rpm_pkg::S_JOIN: begin
        g_we       = 1'b1;
        joined_nxt = joined_r + 1'b1;
        dir_nxt    = rpm_pkg::DIR_UP;
        chk_nxt    = 1'b1;
        state_nxt  = rpm_pkg::S_ADD_RD;
      end

      default: state_nxt = rpm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rpm_pkg::S_IDLE;
      ret_r    <= rpm_pkg::S_PICK_RD;
      fcnt_r   <= '0;
      rng_r    <= 32'd1;
      ov_r     <= 1'b0;
      rdsel_r  <= 1'b0;
      ovf_r    <= 1'b0;
      nbn_r    <= '0;
      dcnt_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      fcnt_r   <= fcnt_nxt;
      rng_r    <= rng_nxt;
      ov_r     <= ov_nxt;
      rdsel_r  <= rdsel_nxt;
      ovf_r    <= ovf_nxt;
      nbn_r    <= nbn_nxt;
      dcnt_r   <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    end_r    <= end_nxt;
    dir_r    <= dir_nxt;
    chk_r    <= chk_nxt;
    idx_r    <= idx_nxt;
    joined_r <= joined_nxt;
    dq_r     <= dq_nxt;
    drem_r   <= drem_nxt;
    dd_r     <= dd_nxt;
    oj_r     <= oj_nxt;
    os_r     <= os_nxt;
    if (nb_we) nb_r[nbn_r[1:0]] <= nb_wd;
  end

  assign busy             = (state_r != rpm_pkg::S_IDLE);
  assign out_valid        = ov_r;
  assign out_read_code    = rdsel_r ? g_rd_r : 3'd0;
  assign out_joined_cells = oj_r;
  assign out_status       = os_r;

endmodule
